// File: design/plm_pkg.sv
// shared types and constants for the polyline lateral offset block
package plm_pkg;

  localparam int CNT_W = 11;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_AXIS_ENABLE = 2'd1;
  localparam logic [1:0] CFG_AXIS_LENGTH = 2'd2;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] d;
  } vertex_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

// File: design/plm_path_mem.sv
// vertex table memory, one write port and one registered read port
module plm_path_mem import plm_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  vertex_t       wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output vertex_t       rd_data_o
);

  vertex_t mem [DEPTH];
  vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/plm_isqrt.sv
// bit-serial integer square root, one root bit per cycle
module plm_isqrt import plm_pkg::*; #(
  parameter int NW = 100,
  parameter int RW = NW / 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] radicand_i,
  output unit_ctl_t     ctl_o,
  output logic [RW-1:0] root_o
);

  localparam int CW = $clog2(RW + 1);

  logic [NW-1:0] rad_q;
  logic [RW+1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [RW+1:0] rem_sh, trial;

  assign rem_sh = {rem_q[RW-1:0], rad_q[NW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign root_o      = root_q;

endmodule

// File: design/plm_divider.sv
// restoring divider, one quotient bit per cycle
module plm_divider import plm_pkg::*; #(
  parameter int DW = 83,
  parameter int RW = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  output unit_ctl_t     ctl_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] num_q;
  logic [RW-1:0] den_q;
  logic [RW:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [RW:0]   rem_sh;

  assign rem_sh = {rem_q[RW-1:0], num_q[DW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        num_q <= {num_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[DW-2:0], 1'b0};
      end
    end
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign quotient_o  = num_q;

endmodule

// File: design/polyline_lateral_offset.sv
// polyline lateral offset: vertex table, segment search and offset datapath
// query steps: a binary search over the vertex table, a table read and a compare
//   per search step, then the vertex reads, the multiply steps, the bit-serial root
//   and the divider
// throughput: one query at a time, the next word is taken once the last is done
// reset: control and config registers clear at once, the datapath registers are not
//   reset, the vertex table is undefined until written
module polyline_lateral_offset import plm_pkg::*; #(
  parameter int MAX_POINTS    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [9:0]         entry_index_i,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic [31:0]        vertex_distance_i,
  input  logic [31:0]        progress_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] lateral_offset_o,
  output logic               offset_valid_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = 68 + 2 * FRACTION_BITS;
  localparam int RW = NW / 2;
  localparam int DW = 67 + FRACTION_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_RD_A     = 4'd3;
  localparam logic [3:0] S_RD_B     = 4'd4;
  localparam logic [3:0] S_LATCH_B  = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_SQRT     = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]        state_q;
  logic [CNT_W-1:0]  count_q;
  logic              enable_q;
  logic [31:0]       length_q;
  logic [CNT_W-1:0]  first_q, len_q, half;
  logic [CNT_W-1:0]  idx_c;
  logic [AW-1:0]     idx_q, rd_addr;
  logic [31:0]       prog_q;
  logic signed [31:0] qx_q, qy_q;
  logic signed [32:0] ax_q, ay_q, ox_q, oy_q, dx_q, dy_q;
  logic [2:0]        step_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_q;
  logic [66:0]       sq_q;
  logic signed [66:0] cross_q, cross_d;
  logic [66:0]       mag_q;
  logic              neg_q;
  logic              res_ok_q;
  logic [31:0]       res_q;
  logic              out_valid_q, out_ok_q;
  logic [31:0]       out_res_q;
  logic              in_fire, out_free, cfg_bad;
  logic              sqrt_start, div_start;
  vertex_t           wr_data, rd_data;
  unit_ctl_t         sqrt_ctl, div_ctl;
  logic [RW-1:0]     root;
  logic [DW-1:0]     quot;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign half        = len_q >> 1;
  assign cfg_bad     = !enable_q || (count_q < CNT_W'(2))
                       || (32'(count_q) > 32'(MAX_POINTS)) || (progress_i > length_q);

  assign wr_data.x = vertex_x_i;
  assign wr_data.y = vertex_y_i;
  assign wr_data.d = vertex_distance_i;

  always_comb begin
    unique case (state_q)
      S_SRCH_RD: rd_addr = AW'(first_q + half);
      S_RD_A:    rd_addr = idx_q - 1'b1;
      default:   rd_addr = idx_q;
    endcase
  end

  always_comb begin
    priority if (first_q < CNT_W'(1)) begin
      idx_c = CNT_W'(1);
    end else if (first_q > count_q - 1'b1) begin
      idx_c = count_q - 1'b1;
    end else begin
      idx_c = first_q;
    end
  end

  always_comb begin
    unique case (step_q)
      3'd0:    begin mul_a = dx_q; mul_b = dx_q; end
      3'd1:    begin mul_a = dy_q; mul_b = dy_q; end
      3'd2:    begin mul_a = dx_q; mul_b = oy_q; end
      default: begin mul_a = dy_q; mul_b = ox_q; end
    endcase
  end

  assign cross_d    = cross_q - 67'(p_q);
  assign sqrt_start = (state_q == S_MUL) && (step_q == 3'd4) && (sq_q != '0);
  assign div_start  = (state_q == S_SQRT) && sqrt_ctl.done;

  plm_path_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && (operation_i == OP_WRITE)
                && (32'(entry_index_i) < 32'(MAX_POINTS))),
    .wr_addr_i (AW'(entry_index_i)),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  plm_isqrt #(.NW(NW), .RW(RW)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (NW'(sq_q) << (2 * FRACTION_BITS)),
    .ctl_o      (sqrt_ctl),
    .root_o     (root)
  );

  plm_divider #(.DW(DW), .RW(RW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DW'(mag_q) << FRACTION_BITS),
    .divisor_i  (root),
    .ctl_o      (div_ctl),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      enable_q <= 1'b0;
      length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POINT_COUNT: count_q  <= cfg_data_i[CNT_W-1:0];
        CFG_AXIS_ENABLE: enable_q <= cfg_data_i[0];
        CFG_AXIS_LENGTH: length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (operation_i == OP_QUERY)) begin
            state_q <= cfg_bad ? S_DONE : S_SRCH_RD;
          end
        end
        S_SRCH_RD:  state_q <= (len_q == '0) ? S_RD_A : S_SRCH_CMP;
        S_SRCH_CMP: state_q <= S_SRCH_RD;
        S_RD_A:     state_q <= S_RD_B;
        S_RD_B:     state_q <= S_LATCH_B;
        S_LATCH_B: begin
          state_q <= S_MUL;
          step_q  <= '0;
        end
        S_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd4) begin
            state_q <= (sq_q == '0) ? S_DONE : S_SQRT;
          end
        end
        S_SQRT: if (sqrt_ctl.done) state_q <= S_DIV;
        S_DIV:  if (div_ctl.done) state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        first_q  <= '0;
        len_q    <= count_q;
        prog_q   <= progress_i;
        qx_q     <= query_x_i;
        qy_q     <= query_y_i;
        res_ok_q <= 1'b0;
        res_q    <= '0;
      end
      S_SRCH_RD: idx_q <= AW'(idx_c);
      S_SRCH_CMP: begin
        if (rd_data.d < prog_q) begin
          first_q <= first_q + half + 1'b1;
          len_q   <= len_q - half - 1'b1;
        end else begin
          len_q <= half;
        end
      end
      S_RD_B: begin
        ax_q <= 33'(signed'(rd_data.x));
        ay_q <= 33'(signed'(rd_data.y));
        ox_q <= 33'(qx_q) - 33'(signed'(rd_data.x));
        oy_q <= 33'(qy_q) - 33'(signed'(rd_data.y));
      end
      S_LATCH_B: begin
        dx_q <= 33'(signed'(rd_data.x)) - ax_q;
        dy_q <= 33'(signed'(rd_data.y)) - ay_q;
      end
      S_MUL: begin
        unique case (step_q)
          3'd1:    sq_q    <= 67'(unsigned'(p_q));
          3'd2:    sq_q    <= sq_q + 67'(unsigned'(p_q));
          3'd3:    cross_q <= 67'(p_q);
          3'd4: begin
            neg_q <= cross_d[66];
            mag_q <= cross_d[66] ? unsigned'(-cross_d) : unsigned'(cross_d);
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_ctl.done) begin
          res_ok_q <= 1'b1;
          if (neg_q) begin
            res_q <= (quot > DW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-quot[31:0]);
          end else begin
            res_q <= (quot > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[31:0];
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_ok_q  <= res_ok_q;
          out_res_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign offset_valid_o   = out_ok_q;
  assign lateral_offset_o = out_res_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !offset_valid_o) |-> (lateral_offset_o == 32'd0))
    else $error("invalid result carries nonzero offset");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (operation_i == OP_QUERY)) |=> (state_q != S_IDLE))
    else $error("query accepted but block stayed idle");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished result not presented");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_ctl.start && div_ctl.start))
    else $error("root and divider started together");

endmodule

// File: tb/tb_polyline_lateral_offset.sv
// testbench for the polyline lateral offset block: directed table, random queries, offset predictor
module tb_polyline_lateral_offset;
  import plm_pkg::*;

  localparam int NPTS = 1024;
  localparam int FB = 16;
  localparam int LIMIT_CYC = 3000000;

  typedef struct {
    logic        op;
    logic [9:0]  idx;
    logic [31:0] vx, vy, vd, prog, qx, qy;
    logic        known;
    logic [31:0] exp_off;
    logic        exp_vld;
  } stim_t;

  typedef struct {
    logic [31:0] off;
    logic        vld;
  } offset_word_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 1, cfg_valid_i = 0;
  logic in_stall_o, out_valid_o, cfg_ready_o, offset_valid_o;
  logic operation_i = 0;
  logic [9:0] entry_index_i = 0;
  logic signed [31:0] vertex_x_i = 0, vertex_y_i = 0, query_x_i = 0, query_y_i = 0;
  logic [31:0] vertex_distance_i = 0, progress_i = 0, cfg_data_i = 0;
  logic [1:0] cfg_index_i = CFG_POINT_COUNT;
  logic signed [31:0] lateral_offset_o;

  logic [31:0] tab_x[NPTS], tab_y[NPTS], tab_d[NPTS];
  bit          tab_written[NPTS];
  logic [10:0] cur_count = 0;
  logic        cur_enable = 0;
  logic [31:0] cur_length = 0;

  offset_word_t expected_offsets[$];
  int  errors = 0, cycles = 0, stalls_on = 1, hold_off = 0;
  bit  quiet = 0;

  polyline_lateral_offset DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [10:0] seek_segment(logic [31:0] key);
    int first, len, half;
    first = 0;
    len = int'(cur_count);
    while (len > 0) begin
      half = len / 2;
      if (tab_d[first + half] < key) begin
        first += half + 1;
        len -= half + 1;
      end else begin
        len = half;
      end
    end
    return 11'(first);
  endfunction

  function automatic logic [127:0] root128(logic [127:0] n);
    logic [127:0] res, bit_v, t;
    res = 0;
    bit_v = 128'd1 << 126;
    while (bit_v != 0 && bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      t = res + bit_v;
      if (n >= t) begin
        n -= t;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic offset_word_t predict_offset(logic [31:0] prog,
                                                  logic [31:0] qx, logic [31:0] qy);
    offset_word_t r;
    int i;
    logic signed [127:0] ax, ay, dx, dy, ox, oy, sq, cr;
    logic [127:0] mag, len, q;
    logic neg;
    r.off = 0;
    r.vld = 0;
    if (!cur_enable || cur_count < 2 || cur_count > NPTS || prog > cur_length) return r;
    i = int'(seek_segment(prog));
    if (i < 1) i = 1;
    if (i > cur_count - 1) i = cur_count - 1;
    ax = $signed(tab_x[i-1]);
    ay = $signed(tab_y[i-1]);
    dx = $signed(tab_x[i]) - ax;
    dy = $signed(tab_y[i]) - ay;
    ox = $signed(qx) - ax;
    oy = $signed(qy) - ay;
    sq = dx * dx + dy * dy;
    if (sq == 0) return r;
    cr = dx * oy - dy * ox;
    neg = cr < 0;
    mag = neg ? -cr : cr;
    len = root128(sq << (2 * FB));
    q = (mag << FB) / len;
    if (neg) begin
      if (q > 128'h80000000) q = 128'h80000000;
      r.off = -q[31:0];
    end else begin
      if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
      r.off = q[31:0];
    end
    r.vld = 1;
    return r;
  endfunction

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    in_valid_i  <= 0;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    case (idx)
      CFG_POINT_COUNT: cur_count = data[10:0];
      CFG_AXIS_ENABLE: cur_enable = data[0];
      CFG_AXIS_LENGTH: cur_length = data;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid_i <= 0;
    while (expected_offsets.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  task automatic send_word(stim_t s);
    offset_word_t e;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    operation_i <= s.op;
    entry_index_i <= s.idx;
    vertex_x_i <= s.vx;
    vertex_y_i <= s.vy;
    vertex_distance_i <= s.vd;
    progress_i <= s.prog;
    query_x_i <= s.qx;
    query_y_i <= s.qy;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    if (s.op == OP_WRITE) begin
      tab_x[s.idx] = s.vx;
      tab_y[s.idx] = s.vy;
      tab_d[s.idx] = s.vd;
      tab_written[s.idx] = 1;
    end else begin
      e = predict_offset(s.prog, s.qx, s.qy);
      if (s.known && (e.off !== s.exp_off || e.vld !== s.exp_vld)) begin
        $display("%0t table row disagrees: expected %h/%b, predicted %h/%b",
                 $time, s.exp_off, s.exp_vld, e.off, e.vld);
        errors++;
      end
      expected_offsets.push_back(e);
    end
    @(negedge clk_i);
  endtask

  function automatic stim_t vtx(int i, logic [31:0] x, logic [31:0] y, logic [31:0] d);
    stim_t s;
    s = '{default: 0};
    s.op = OP_WRITE;
    s.idx = 10'(i);
    s.vx = x;
    s.vy = y;
    s.vd = d;
    return s;
  endfunction

  function automatic stim_t qry(logic [31:0] p, logic [31:0] x, logic [31:0] y);
    stim_t s;
    s = '{default: 0};
    s.op = OP_QUERY;
    s.prog = p;
    s.qx = x;
    s.qy = y;
    s.vx = $urandom;
    s.vy = $urandom;
    s.vd = $urandom;
    s.idx = 10'($urandom);
    return s;
  endfunction

  function automatic stim_t qry_known(logic [31:0] p, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] off, logic v);
    stim_t s;
    s = qry(p, x, y);
    s.known = 1;
    s.exp_off = off;
    s.exp_vld = v;
    return s;
  endfunction

  // receiver: random stall bursts, long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_stall_i <= 1;
        hold_off--;
      end else if (stalls_on && !quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    offset_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_offsets.size() == 0) begin
        $display("%0t unexpected word: actual %h/%b", $time, lateral_offset_o, offset_valid_o);
        errors++;
      end else begin
        e = expected_offsets.pop_front();
        if (lateral_offset_o !== e.off) begin
          $display("%0t offset mismatch: expected %h actual %h", $time, e.off, lateral_offset_o);
          errors++;
        end
        if (offset_valid_o !== e.vld) begin
          $display("%0t valid flag mismatch: expected %b actual %b",
                   $time, e.vld, offset_valid_o);
          errors++;
        end
      end
    end
  end

  task automatic load_path(int n, bit sorted);
    logic [31:0] d, x, y;
    d = 0;
    x = $urandom;
    y = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin x = $urandom; y = $urandom; end
        1: begin x = x + $signed($urandom_range(0, 65535) - 32768); y = y + 16'h8000; end
        default: begin
          x = x + $signed($urandom_range(0, 2000000) - 1000000);
          y = y + $signed($urandom_range(0, 2000000) - 1000000);
        end
      endcase
      d = sorted ? d + $urandom_range(0, 3 << 16) : $urandom;
      send_word(vtx(i, x, y, d));
    end
    write_cfg(CFG_AXIS_LENGTH, $urandom_range(0, 9) == 0 ? 32'hFFFFFFFF : d + 32'h10000);
  endtask

  function automatic logic [31:0] rand_prog();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, tab_d[cur_count - 1] + 32'h20000);
  endfunction

  initial begin
    stim_t rows[$];
    int n, sent;
    for (int i = 0; i < NPTS; i++) tab_written[i] = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // reset config: every query invalid
    rows.push_back(qry_known(0, 0, 0, 0, 0));
    rows.push_back(qry_known(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 0));
    foreach (rows[i]) send_word(rows[i]);
    rows.delete();
    drain_results();

    write_cfg(CFG_POINT_COUNT, 1);
    write_cfg(CFG_AXIS_ENABLE, 1);
    write_cfg(CFG_AXIS_LENGTH, 32'hFFFFFFFF);
    rows.push_back(vtx(0, 0, 0, 0));
    rows.push_back(vtx(1, 32'h00010000, 0, 32'h00010000));
    rows.push_back(vtx(2, 32'h00010000, 0, 32'h00020000));
    rows.push_back(vtx(3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF));
    rows.push_back(vtx(4, 32'h80000000, 32'h80000000, 32'hFFFFFFFF));
    rows.push_back(qry_known(0, 0, 32'h00010000, 0, 0));
    foreach (rows[i]) send_word(rows[i]);
    rows.delete();
    drain_results();
    write_cfg(CFG_POINT_COUNT, 5);
    // unit segment along x: offset is y; zero span invalid; far corners saturate
    rows.push_back(qry_known(0, 32'h00008000, 32'h00010000, 32'h00010000, 1));
    rows.push_back(qry_known(32'h00008000, 32'h00005000, 32'hFFFF0000, 32'hFFFF0000, 1));
    rows.push_back(qry_known(32'h00018000, 0, 32'h00010000, 0, 0));
    rows.push_back(qry_known(32'h00010000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
    rows.push_back(qry_known(32'h00010000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1));
    rows.push_back(qry(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    rows.push_back(qry(32'h00030000, 32'h12345678, 32'h9ABCDEF0));
    foreach (rows[i]) send_word(rows[i]);
    rows.delete();
    drain_results();
    write_cfg(CFG_AXIS_LENGTH, 32'h00008000);
    send_word(qry_known(32'h00008001, 0, 0, 0, 0));
    send_word(qry_known(32'h00008000, 0, 32'h00010000, 32'h00010000, 1));
    drain_results();
    write_cfg(CFG_AXIS_ENABLE, 0);
    send_word(qry_known(0, 0, 32'h00010000, 0, 0));
    drain_results();
    write_cfg(CFG_AXIS_ENABLE, 1);
    write_cfg(CFG_POINT_COUNT, 11'd1025);
    send_word(qry_known(0, 0, 32'h00010000, 0, 0));
    drain_results();

    // random phases over paths of varied size
    sent = 0;
    for (int ph = 0; sent < 620; ph++) begin
      if (ph == 3) n = 400;
      else n = $urandom_range(2, ph % 4 == 0 ? 40 : 12);
      write_cfg(CFG_POINT_COUNT, n);
      load_path(n, ph % 5 != 4);
      sent += n;
      if (ph == 2) hold_off = 600;
      if (sent > 560) quiet = 1;
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(vtx($urandom_range(0, n - 1), $urandom, $urandom,
                        $urandom_range(0, 9) < 8 ? tab_d[$urandom_range(0, n - 1)] : $urandom));
        else
          send_word(qry(rand_prog(), $urandom_range(0, 4) == 0 ? $urandom
                                     : tab_x[$urandom_range(0, n - 1)] + $urandom_range(0, 1 << 20),
                        $urandom_range(0, 4) == 0 ? $urandom
                                     : tab_y[$urandom_range(0, n - 1)] - $urandom_range(0, 1 << 20)));
        sent++;
      end
      in_valid_i <= 0;
      drain_results();
    end

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
